>>> hw/rtl/fmct_pkg.sv
// Shared types and constants for the feature map channel tiler.
package fmct_pkg;

   localparam int DATA_W      = 16;
   localparam int INDEX_W     = 32;
   localparam int POS_W       = 5;
   localparam int GROUP_W     = 12;
   localparam int ROW_W       = 10;
   localparam int COL_W       = 10;
   localparam int CHAN_W      = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [10:0] MAX_ROWS  = 11'd1024;
   localparam logic [10:0] MAX_COLS  = 11'd1024;
   localparam logic [12:0] MAX_CHANS = 13'd4096;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_STRIDE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_STRIDE = 3'd4;

   typedef struct packed {
      logic [10:0] frame_height;
      logic [10:0] frame_width;
      logic [12:0] channel_count;
      logic [23:0] line_stride_bytes;
      logic [31:0] surface_stride_bytes;
   } fmct_cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic [POS_W-1:0]         pos;
      logic [GROUP_W-1:0]       group;
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic                     ch_last;
      logic                     frame_last;
   } fmct_entry_type;

endpackage

>>> hw/rtl/fmct_front.sv
// Front end: accepts samples, tracks row/column/channel position, classifies each item.
module fmct_front #(
   parameter int TILE_CHANNELS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fmct_pkg::fmct_cfg_type  cfg,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,     // [15:0] sample_value
   output logic                    push_valid,
   input  logic                    push_ready,
   output fmct_pkg::fmct_entry_type push_entry
);
   import fmct_pkg::*;

   localparam logic [POS_W-1:0] PosMax = POS_W'(TILE_CHANNELS - 1);

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [CHAN_W-1:0]  ch_ff, ch_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [GROUP_W-1:0] grp_ff, grp_in;

   logic [10:0] nrows, ncols;
   logic [12:0] nchans;
   logic        ch_last, col_last, row_last, accept;

   always_comb begin
      if (cfg.frame_height == '0) nrows = 11'd1;
      else if (cfg.frame_height > MAX_ROWS) nrows = MAX_ROWS;
      else nrows = cfg.frame_height;

      if (cfg.frame_width == '0) ncols = 11'd1;
      else if (cfg.frame_width > MAX_COLS) ncols = MAX_COLS;
      else ncols = cfg.frame_width;

      if (cfg.channel_count == '0) nchans = 13'd1;
      else if (cfg.channel_count > MAX_CHANS) nchans = MAX_CHANS;
      else nchans = cfg.channel_count;
   end

   // A counter at or past its count sits on its last position
   assign ch_last  = ({1'b0, ch_ff} + 13'd1) >= nchans;
   assign col_last = ({1'b0, col_ff} + 11'd1) >= ncols;
   assign row_last = ({1'b0, row_ff} + 11'd1) >= nrows;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      push_entry.sample     = req_tdata;
      push_entry.pos        = pos_ff;
      push_entry.group      = grp_ff;
      push_entry.row        = row_ff;
      push_entry.col        = col_ff;
      push_entry.ch_last    = ch_last;
      push_entry.frame_last = ch_last && col_last && row_last;
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      ch_in  = ch_ff;
      pos_in = pos_ff;
      grp_in = grp_ff;
      if (accept) begin
         if (ch_last) begin
            ch_in  = '0;
            pos_in = '0;
            grp_in = '0;
            if (col_last) begin
               col_in = '0;
               row_in = row_last ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end else begin
            ch_in = ch_ff + CHAN_W'(1);
            if (pos_ff >= PosMax) begin
               pos_in = '0;
               grp_in = grp_ff + GROUP_W'(1);
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         ch_ff  <= '0;
         pos_ff <= '0;
         grp_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         ch_ff  <= ch_in;
         pos_ff <= pos_in;
         grp_ff <= grp_in;
      end
   end

endmodule

>>> hw/rtl/fmct_queue.sv
// Short queue that decouples the front end from the write generator.
module fmct_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  fmct_pkg::fmct_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output fmct_pkg::fmct_entry_type pop_entry
);
   import fmct_pkg::*;

   fmct_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/fmct_back.sv
// Back end: forms the tiled index and emits the sample write plus any padding writes.
module fmct_back #(
   parameter int TILE_CHANNELS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fmct_pkg::fmct_cfg_type   cfg,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  fmct_pkg::fmct_entry_type pop_entry,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,  // [31:0] dest_index, [47:32] write_value
   output logic [1:0]               rsp_tuser,  // [0] is_padding, [1] frame_done
   output logic                     rsp_tlast   // run_last
);
   import fmct_pkg::*;

   localparam logic [POS_W-1:0]   PosMax = POS_W'(TILE_CHANNELS - 1);
   localparam logic [INDEX_W-1:0] TileW  = INDEX_W'(TILE_CHANNELS);

   // Product stage
   logic               a_valid_ff, a_valid_in;
   logic [INDEX_W-1:0] a_grp_ff, a_grp_in;
   logic [INDEX_W-1:0] a_row_ff, a_row_in;
   logic [INDEX_W-1:0] a_col_ff, a_col_in;
   logic [POS_W-1:0]   a_pos_ff, a_pos_in;
   logic [DATA_W-1:0]  a_sample_ff, a_sample_in;
   logic               a_ch_last_ff, a_ch_last_in;
   logic               a_frame_last_ff, a_frame_last_in;

   // Write expander / output register
   logic               e_valid_ff, e_valid_in;
   logic [INDEX_W-1:0] e_dest_ff, e_dest_in;
   logic [DATA_W-1:0]  e_value_ff, e_value_in;
   logic               e_pad_ff, e_pad_in;
   logic               e_last_ff, e_last_in;
   logic               e_done_ff, e_done_in;
   logic [POS_W-1:0]   e_pos_ff, e_pos_in;
   logic               e_frame_last_ff, e_frame_last_in;

   logic               e_free, a_free, a_last;
   logic [31:0]        grp_half;
   logic [22:0]        line_half;

   assign grp_half  = {1'b0, cfg.surface_stride_bytes[31:1]};
   assign line_half = cfg.line_stride_bytes[23:1];

   assign e_free    = !e_valid_ff || (rsp_tready && e_last_ff);
   assign a_free    = !a_valid_ff || e_free;
   assign pop_ready = a_free;
   assign a_last    = !a_ch_last_ff || (a_pos_ff == PosMax);

   always_comb begin
      a_valid_in      = a_valid_ff;
      a_grp_in        = a_grp_ff;
      a_row_in        = a_row_ff;
      a_col_in        = a_col_ff;
      a_pos_in        = a_pos_ff;
      a_sample_in     = a_sample_ff;
      a_ch_last_in    = a_ch_last_ff;
      a_frame_last_in = a_frame_last_ff;
      if (a_free) begin
         a_valid_in      = pop_valid;
         a_grp_in        = INDEX_W'(INDEX_W'(pop_entry.group) * grp_half);
         a_row_in        = INDEX_W'(INDEX_W'(pop_entry.row) * INDEX_W'(line_half));
         a_col_in        = INDEX_W'(INDEX_W'(pop_entry.col) * TileW);
         a_pos_in        = pop_entry.pos;
         a_sample_in     = pop_entry.sample;
         a_ch_last_in    = pop_entry.ch_last;
         a_frame_last_in = pop_entry.frame_last;
      end
   end

   always_comb begin
      e_valid_in      = e_valid_ff;
      e_dest_in       = e_dest_ff;
      e_value_in      = e_value_ff;
      e_pad_in        = e_pad_ff;
      e_last_in       = e_last_ff;
      e_done_in       = e_done_ff;
      e_pos_in        = e_pos_ff;
      e_frame_last_in = e_frame_last_ff;
      if (e_free) begin
         // Load the sample write of the next item
         e_valid_in      = a_valid_ff;
         e_dest_in       = a_grp_ff + a_row_ff + a_col_ff + INDEX_W'(a_pos_ff);
         e_value_in      = a_sample_ff;
         e_pad_in        = 1'b0;
         e_last_in       = a_last;
         e_done_in       = a_last && a_frame_last_ff;
         e_pos_in        = a_pos_ff;
         e_frame_last_in = a_frame_last_ff;
      end else if (rsp_tready) begin
         // Advance to the next padding position of the group
         e_dest_in  = e_dest_ff + INDEX_W'(1);
         e_value_in = '0;
         e_pad_in   = 1'b1;
         e_pos_in   = e_pos_ff + POS_W'(1);
         e_last_in  = (e_pos_ff + POS_W'(1)) == PosMax;
         e_done_in  = ((e_pos_ff + POS_W'(1)) == PosMax) && e_frame_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         e_valid_ff <= e_valid_in;
      end
      a_grp_ff        <= a_grp_in;
      a_row_ff        <= a_row_in;
      a_col_ff        <= a_col_in;
      a_pos_ff        <= a_pos_in;
      a_sample_ff     <= a_sample_in;
      a_ch_last_ff    <= a_ch_last_in;
      a_frame_last_ff <= a_frame_last_in;
      e_dest_ff       <= e_dest_in;
      e_value_ff      <= e_value_in;
      e_pad_ff        <= e_pad_in;
      e_last_ff       <= e_last_in;
      e_done_ff       <= e_done_in;
      e_pos_ff        <= e_pos_in;
      e_frame_last_ff <= e_frame_last_in;
   end

   assign rsp_tvalid = e_valid_ff;
   assign rsp_tdata  = {e_value_ff, e_dest_ff};
   assign rsp_tuser  = {e_done_ff, e_pad_ff};
   assign rsp_tlast  = e_last_ff;

endmodule

>>> hw/rtl/feature_map_channel_tiler_core.sv
// Top level of the feature map channel tiler: configuration registers and block wiring.
// Each item's first write passes the queue, the product stage and the output register.
// Throughput: one item per cycle while rsp_tready is high; the last channel of a pixel
// also holds the output for one padding write per remaining position of its group.
// The output register sets the rate: one write per cycle while rsp_tready is high.
// Reset: counters cleared to zero, pipeline emptied, registers to 1, 1, 1, 16, 16.
module feature_map_channel_tiler_core #(
   parameter int TILE_CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] dest_index, [47:32] write_value
   output logic [1:0]  rsp_tuser,   // [0] is_padding, [1] frame_done
   output logic        rsp_tlast    // run_last
);
   import fmct_pkg::*;

   fmct_cfg_type   cfg_ff, cfg_in;
   fmct_entry_type push_entry, pop_entry;
   logic           push_valid, push_ready, pop_valid, pop_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_HEIGHT:   cfg_in.frame_height         = csr_data[10:0];
            CSR_FRAME_WIDTH:    cfg_in.frame_width          = csr_data[10:0];
            CSR_CHANNEL_COUNT:  cfg_in.channel_count        = csr_data[12:0];
            CSR_LINE_STRIDE:    cfg_in.line_stride_bytes    = csr_data[23:0];
            CSR_SURFACE_STRIDE: cfg_in.surface_stride_bytes = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_height         <= 11'd1;
         cfg_ff.frame_width          <= 11'd1;
         cfg_ff.channel_count        <= 13'd1;
         cfg_ff.line_stride_bytes    <= 24'd16;
         cfg_ff.surface_stride_bytes <= 32'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fmct_front #(
      .TILE_CHANNELS (TILE_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   fmct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   fmct_back #(
      .TILE_CHANNELS (TILE_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
